// ===== design/cpsa_pkg.sv =====
package cpsa_pkg;

   localparam int NUM_MODULES_DEF      = 4;
   localparam int CELLS_PER_MODULE_DEF = 12;
   localparam int TEMPS_PER_MODULE_DEF = 5;

   localparam int VOLT_W     = 16;
   localparam int TEMP_W     = 8;
   localparam int IDX_W      = 4;
   localparam int LOC_W      = 2 * IDX_W;
   localparam int POS_W      = IDX_W + 1;
   localparam int SAMPLE_W   = 17;
   localparam int VSUM_W     = 24;
   localparam int TSUM_W     = 16;
   localparam int FLAG_W     = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 104;

   localparam int FLAG_V_HIGH = 5;
   localparam int FLAG_V_LOW  = 4;
   localparam int FLAG_V_DIFF = 3;
   localparam int FLAG_T_HIGH = 2;
   localparam int FLAG_T_LOW  = 1;
   localparam int FLAG_T_DIFF = 0;

   localparam logic [VOLT_W-1:0] VOLT_HIGH_RST = 16'd4200;
   localparam logic [VOLT_W-1:0] VOLT_LOW_RST  = 16'd2800;
   localparam logic [VOLT_W-1:0] VOLT_DIFF_RST = 16'd100;
   localparam logic [TEMP_W-1:0] TEMP_HIGH_RST = 8'd55;
   // Two's complement of minus twenty.
   localparam logic [TEMP_W-1:0] TEMP_LOW_RST  = 8'hEC;
   localparam logic [TEMP_W-1:0] TEMP_DIFF_RST = 8'd10;

   typedef enum logic {
      SAMPLE_VOLT = 1'b0,
      SAMPLE_TEMP = 1'b1
   } sample_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLT_HIGH = 3'd0,
      CSR_VOLT_LOW  = 3'd1,
      CSR_VOLT_DIFF = 3'd2,
      CSR_TEMP_HIGH = 3'd3,
      CSR_TEMP_LOW  = 3'd4,
      CSR_TEMP_DIFF = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [VOLT_W-1:0] volt_high;
      logic [VOLT_W-1:0] volt_low;
      logic [VOLT_W-1:0] volt_diff;
      logic [TEMP_W-1:0] temp_high;
      logic [TEMP_W-1:0] temp_low;
      logic [TEMP_W-1:0] temp_diff;
   } limits_type;

   // Locations are zero-based, module in the high nibble.
   typedef struct packed {
      logic [VOLT_W-1:0] volt_max;
      logic [VOLT_W-1:0] volt_min;
      logic [LOC_W-1:0]  volt_max_loc;
      logic [LOC_W-1:0]  volt_min_loc;
      logic [TEMP_W-1:0] temp_max;
      logic [TEMP_W-1:0] temp_min;
      logic [VSUM_W-1:0] volt_sum;
      logic [TSUM_W-1:0] temp_sum;
   } scan_type;

   typedef struct packed {
      logic [VOLT_W-1:0] max_cell_v;
      logic [VOLT_W-1:0] min_cell_v;
      logic [POS_W-1:0]  max_v_module;
      logic [POS_W-1:0]  max_v_cell;
      logic [POS_W-1:0]  min_v_module;
      logic [POS_W-1:0]  min_v_cell;
      logic [TEMP_W-1:0] max_temp;
      logic [TEMP_W-1:0] min_temp;
      logic [VOLT_W-1:0] avg_cell_v;
      logic [TEMP_W-1:0] avg_temp;
      logic [FLAG_W-1:0] alarm_flags;
   } result_type;

endpackage

// ===== design/cell_pack_stats_alarm_top.sv =====
// Channel   Direction  Handshake           Payload
// req       in         req_tvalid/tready   tdata, tuser = operation, tlast = last
// rsp       out        rsp_tvalid/tready   tdata = one scan report
// csr       in         csr_we              csr_index, csr_wdata
//
// One item is accepted per cycle while the result register is empty or being taken; running
// extremes and sums update in the cycle of the item. After the last item of a scan a report
// passes the snapshot, reciprocal product and result registers, in that order.
// Reset clears the scan state and loads the default limits; there is no clearing pass.
// All stages advance together whenever the result register is empty or being taken.
module cell_pack_stats_alarm_top #(
   parameter int NUM_MODULES      = cpsa_pkg::NUM_MODULES_DEF,
   parameter int CELLS_PER_MODULE = cpsa_pkg::CELLS_PER_MODULE_DEF,
   parameter int TEMPS_PER_MODULE = cpsa_pkg::TEMPS_PER_MODULE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // module_index[3:0], cell_index[7:4], sample_value[24:8], zero[31:25]
   input  logic [cpsa_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // max_cell_v[15:0], min_cell_v[31:16], max_v_module[36:32], max_v_cell[41:37],
   // min_v_module[46:42], min_v_cell[51:47], max_temp[59:52], min_temp[67:60],
   // avg_cell_v[83:68], avg_temp[91:84], alarm_flags[97:92], zero[103:98]
   output logic [cpsa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [cpsa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cpsa_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int VOLT_DIV = NUM_MODULES * CELLS_PER_MODULE;
   localparam int TEMP_DIV = NUM_MODULES * TEMPS_PER_MODULE;
   localparam int PAY_W    = 98;

   cpsa_pkg::limits_type   limits_ff;
   cpsa_pkg::scan_type     snap;
   cpsa_pkg::result_type   result;
   logic                   snap_valid;
   logic                   result_valid;
   logic                   advance;
   logic                   accept;

   assign advance    = !result_valid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.volt_high <= cpsa_pkg::VOLT_HIGH_RST;
         limits_ff.volt_low  <= cpsa_pkg::VOLT_LOW_RST;
         limits_ff.volt_diff <= cpsa_pkg::VOLT_DIFF_RST;
         limits_ff.temp_high <= cpsa_pkg::TEMP_HIGH_RST;
         limits_ff.temp_low  <= cpsa_pkg::TEMP_LOW_RST;
         limits_ff.temp_diff <= cpsa_pkg::TEMP_DIFF_RST;
      end else if (csr_we) begin
         unique case (cpsa_pkg::csr_index_type'(csr_index))
            cpsa_pkg::CSR_VOLT_HIGH: limits_ff.volt_high <= csr_wdata;
            cpsa_pkg::CSR_VOLT_LOW:  limits_ff.volt_low  <= csr_wdata;
            cpsa_pkg::CSR_VOLT_DIFF: limits_ff.volt_diff <= csr_wdata;
            cpsa_pkg::CSR_TEMP_HIGH: limits_ff.temp_high <= csr_wdata[cpsa_pkg::TEMP_W-1:0];
            cpsa_pkg::CSR_TEMP_LOW:  limits_ff.temp_low  <= csr_wdata[cpsa_pkg::TEMP_W-1:0];
            cpsa_pkg::CSR_TEMP_DIFF: limits_ff.temp_diff <= csr_wdata[cpsa_pkg::TEMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   cpsa_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .accept       (accept),
      .kind         (req_tuser),
      .module_index (req_tdata[3:0]),
      .cell_index   (req_tdata[7:4]),
      .sample_value (req_tdata[24:8]),
      .last         (req_tlast),
      .snap         (snap),
      .snap_valid   (snap_valid)
   );

   cpsa_report #(
      .VOLT_DIV (VOLT_DIV),
      .TEMP_DIV (TEMP_DIV)
   ) u_report (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .snap         (snap),
      .snap_valid   (snap_valid),
      .limits       (limits_ff),
      .result       (result),
      .result_valid (result_valid)
   );

   assign rsp_tvalid = result_valid;
   assign rsp_tdata  = {{(cpsa_pkg::RSP_DATA_W - PAY_W){1'b0}},
                        result.alarm_flags,
                        result.avg_temp,
                        result.avg_cell_v,
                        result.min_temp,
                        result.max_temp,
                        result.min_v_cell,
                        result.min_v_module,
                        result.max_v_cell,
                        result.max_v_module,
                        result.min_cell_v,
                        result.max_cell_v};

endmodule

// ===== design/cpsa_accum.sv =====
module cpsa_accum (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            accept,
   input  logic                            kind,
   input  logic [cpsa_pkg::IDX_W-1:0]      module_index,
   input  logic [cpsa_pkg::IDX_W-1:0]      cell_index,
   input  logic [cpsa_pkg::SAMPLE_W-1:0]   sample_value,
   input  logic                            last,
   output cpsa_pkg::scan_type              snap,
   output logic                            snap_valid
);

   cpsa_pkg::scan_type                 acc_ff, acc_in;
   cpsa_pkg::scan_type                 snap_ff;
   logic                               seen_v_ff, seen_v_in;
   logic                               seen_t_ff, seen_t_in;
   logic                               snap_valid_ff;
   logic [cpsa_pkg::VOLT_W-1:0]        volt;
   logic [cpsa_pkg::TEMP_W-1:0]        temp;
   logic [cpsa_pkg::LOC_W-1:0]         loc;

   assign volt = sample_value[cpsa_pkg::VOLT_W-1:0];
   assign temp = sample_value[cpsa_pkg::TEMP_W-1:0];
   assign loc  = {module_index, cell_index};

   always_comb begin
      acc_in    = acc_ff;
      seen_v_in = seen_v_ff;
      seen_t_in = seen_t_ff;
      if (kind == cpsa_pkg::SAMPLE_VOLT) begin
         if (!seen_v_ff) begin
            acc_in.volt_max     = volt;
            acc_in.volt_min     = volt;
            acc_in.volt_max_loc = loc;
            acc_in.volt_min_loc = loc;
            seen_v_in           = 1'b1;
         end else begin
            if (volt > acc_ff.volt_max) begin
               acc_in.volt_max     = volt;
               acc_in.volt_max_loc = loc;
            end
            if (volt < acc_ff.volt_min) begin
               acc_in.volt_min     = volt;
               acc_in.volt_min_loc = loc;
            end
         end
         acc_in.volt_sum = acc_ff.volt_sum + cpsa_pkg::VSUM_W'(volt);
      end else begin
         if (!seen_t_ff) begin
            acc_in.temp_max = temp;
            acc_in.temp_min = temp;
            seen_t_in       = 1'b1;
         end else begin
            if ($signed(temp) > $signed(acc_ff.temp_max)) begin
               acc_in.temp_max = temp;
            end
            if ($signed(temp) < $signed(acc_ff.temp_min)) begin
               acc_in.temp_min = temp;
            end
         end
         acc_in.temp_sum = acc_ff.temp_sum
                         + {{(cpsa_pkg::TSUM_W - cpsa_pkg::TEMP_W){temp[cpsa_pkg::TEMP_W-1]}},
                            temp};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         seen_v_ff     <= 1'b0;
         seen_t_ff     <= 1'b0;
         snap_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (last) begin
               acc_ff    <= '0;
               seen_v_ff <= 1'b0;
               seen_t_ff <= 1'b0;
            end else begin
               acc_ff    <= acc_in;
               seen_v_ff <= seen_v_in;
               seen_t_ff <= seen_t_in;
            end
         end
         if (advance) begin
            snap_valid_ff <= accept && last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         snap_ff <= acc_in;
      end
   end

   assign snap       = snap_ff;
   assign snap_valid = snap_valid_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> !seen_v_ff && !seen_t_ff)
      else $error("scan state not cleared after the last item");

   a_volt_order: assert property (@(posedge clock) disable iff (reset)
      seen_v_ff |-> acc_ff.volt_max >= acc_ff.volt_min)
      else $error("voltage maximum below minimum");

   a_temp_unseen_zero: assert property (@(posedge clock) disable iff (reset)
      !seen_t_ff |-> acc_ff.temp_max == '0 && acc_ff.temp_min == '0 && acc_ff.temp_sum == '0)
      else $error("temperature state not clear before the first temperature");

   a_snap_on_last: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> snap_valid_ff)
      else $error("last item did not produce a snapshot");

endmodule

// ===== design/cpsa_report.sv =====
module cpsa_report #(
   parameter int VOLT_DIV = cpsa_pkg::NUM_MODULES_DEF * cpsa_pkg::CELLS_PER_MODULE_DEF,
   parameter int TEMP_DIV = cpsa_pkg::NUM_MODULES_DEF * cpsa_pkg::TEMPS_PER_MODULE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  cpsa_pkg::scan_type      snap,
   input  logic                    snap_valid,
   input  cpsa_pkg::limits_type    limits,
   output cpsa_pkg::result_type    result,
   output logic                    result_valid
);

   // Division by a constant: multiply by ceil(2^S / D) and shift right by S.
   // With S = sum width + ceil(log2 D) the quotient is exact over the sum range.
   localparam int VK    = $clog2(VOLT_DIV);
   localparam int VS    = cpsa_pkg::VSUM_W + VK;
   localparam int VM_W  = cpsa_pkg::VSUM_W + 1;
   localparam int VP_W  = cpsa_pkg::VSUM_W + VM_W;
   localparam longint unsigned VM_FULL =
      ((64'd1 << VS) + 64'(VOLT_DIV) - 64'd1) / 64'(VOLT_DIV);
   localparam logic [VM_W-1:0] VM = VM_W'(VM_FULL);

   localparam int TK    = $clog2(TEMP_DIV);
   localparam int TS    = cpsa_pkg::TSUM_W + TK;
   localparam int TM_W  = cpsa_pkg::TSUM_W + 1;
   localparam int TP_W  = cpsa_pkg::TSUM_W + TM_W;
   localparam longint unsigned TM_FULL =
      ((64'd1 << TS) + 64'(TEMP_DIV) - 64'd1) / 64'(TEMP_DIV);
   localparam logic [TM_W-1:0] TM = TM_W'(TM_FULL);

   localparam int VD_W = cpsa_pkg::VOLT_W + 1;
   localparam int TD_W = cpsa_pkg::TEMP_W + 2;

   logic                            b_valid_ff;
   cpsa_pkg::scan_type              b_scan_ff;
   logic [VP_W-1:0]                 vprod_ff, vprod_in;
   logic [TP_W-1:0]                 tprod_ff, tprod_in;
   logic                            tneg_ff;
   logic [cpsa_pkg::FLAG_W-1:0]     flags_ff, flags_in;
   logic                            tneg;
   logic [cpsa_pkg::TSUM_W-1:0]     tmag;
   logic [VD_W-1:0]                 vdiff;
   logic [TD_W-1:0]                 tdiff;

   logic                            rsp_valid_ff;
   cpsa_pkg::result_type            rsp_ff, rsp_in;
   logic [VP_W-1:0]                 vq;
   logic [TP_W-1:0]                 tq;

   always_comb begin
      tneg     = snap.temp_sum[cpsa_pkg::TSUM_W-1];
      tmag     = tneg ? (~snap.temp_sum + 1'b1) : snap.temp_sum;
      vprod_in = VP_W'(snap.volt_sum) * VP_W'(VM);
      tprod_in = TP_W'(tmag) * TP_W'(TM);
      vdiff    = {1'b0, snap.volt_max} - {1'b0, snap.volt_min};
      tdiff    = {{2{snap.temp_max[cpsa_pkg::TEMP_W-1]}}, snap.temp_max}
               - {{2{snap.temp_min[cpsa_pkg::TEMP_W-1]}}, snap.temp_min};
      flags_in = '0;
      flags_in[cpsa_pkg::FLAG_V_HIGH] = snap.volt_max > limits.volt_high;
      flags_in[cpsa_pkg::FLAG_V_LOW]  = snap.volt_min < limits.volt_low;
      flags_in[cpsa_pkg::FLAG_V_DIFF] = $signed(vdiff) > $signed({1'b0, limits.volt_diff});
      flags_in[cpsa_pkg::FLAG_T_HIGH] = $signed(snap.temp_max) > $signed(limits.temp_high);
      flags_in[cpsa_pkg::FLAG_T_LOW]  = $signed(snap.temp_min) < $signed(limits.temp_low);
      flags_in[cpsa_pkg::FLAG_T_DIFF] = $signed(tdiff) > $signed({2'b00, limits.temp_diff});
   end

   always_comb begin
      vq = vprod_ff >> VS;
      tq = tprod_ff >> TS;
      rsp_in.max_cell_v   = b_scan_ff.volt_max;
      rsp_in.min_cell_v   = b_scan_ff.volt_min;
      rsp_in.max_v_module = {1'b0, b_scan_ff.volt_max_loc[cpsa_pkg::LOC_W-1:cpsa_pkg::IDX_W]}
                          + 1'b1;
      rsp_in.max_v_cell   = {1'b0, b_scan_ff.volt_max_loc[cpsa_pkg::IDX_W-1:0]} + 1'b1;
      rsp_in.min_v_module = {1'b0, b_scan_ff.volt_min_loc[cpsa_pkg::LOC_W-1:cpsa_pkg::IDX_W]}
                          + 1'b1;
      rsp_in.min_v_cell   = {1'b0, b_scan_ff.volt_min_loc[cpsa_pkg::IDX_W-1:0]} + 1'b1;
      rsp_in.max_temp     = b_scan_ff.temp_max;
      rsp_in.min_temp     = b_scan_ff.temp_min;
      rsp_in.avg_cell_v   = (vq > VP_W'(16'hFFFF)) ? 16'hFFFF : vq[cpsa_pkg::VOLT_W-1:0];
      if (tneg_ff) begin
         rsp_in.avg_temp = (tq > TP_W'(128)) ? 8'h80 : (~tq[cpsa_pkg::TEMP_W-1:0] + 1'b1);
      end else begin
         rsp_in.avg_temp = (tq > TP_W'(127)) ? 8'h7F : tq[cpsa_pkg::TEMP_W-1:0];
      end
      rsp_in.alarm_flags  = flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff   <= snap_valid;
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_scan_ff <= snap;
         vprod_ff  <= vprod_in;
         tprod_ff  <= tprod_in;
         tneg_ff   <= tneg;
         flags_ff  <= flags_in;
         rsp_ff    <= rsp_in;
      end
   end

   assign result       = rsp_ff;
   assign result_valid = rsp_valid_ff;

endmodule
